// ===== design/lwsel_pkg.sv =====
// Shared constants, codes and the stored record type for the least loaded worker selector.
// Depends on nothing; least_loaded_worker_select takes everything from here by scoped names.
package lwsel_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int KEY_BITS    = 32;

  // Only the low key bits that fit the 32 bit port can ever be stored.
  localparam int KEY_W = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SELECT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NONE      = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             en;
    logic [15:0]      load;
    logic [15:0]      limit;
  } record_t;

endpackage

// ===== design/least_loaded_worker_select.sv =====
// Least loaded worker selector: worker table held in one synchronous memory with a
// sequential scan engine. Depends on lwsel_pkg.

// An add or select transfer scans the table before its result is offered: the worker
// records sit in a single memory with one registered read port, so the engine walks the
// valid entries one per cycle, checking for a duplicate key on an add and keeping the
// running least loaded eligible entry on a select. A clear or an unused operation code
// goes straight to the finishing state. Only one item is in work at a time; while its
// result waits in the output register the next item may already be accepted and
// scanned. Records that lie at or beyond the fill count are never read, so the memory
// needs no clearing pass after reset and a clear just zeroes the fill count.
module least_loaded_worker_select (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] worker_key,
  input  logic        worker_enabled,
  input  logic [15:0] worker_load,
  input  logic [15:0] worker_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  chosen_index,
  output logic [31:0] chosen_key,
  output logic [15:0] chosen_load
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;

  // The worker table proper.
  lwsel_pkg::record_t mem [lwsel_pkg::MAX_WORKERS];
  lwsel_pkg::record_t rd_data;
  lwsel_pkg::record_t wr_data;
  logic               mem_we;
  logic [lwsel_pkg::IDX_W-1:0] rd_addr;
  logic [lwsel_pkg::IDX_W-1:0] wr_addr;

  logic [lwsel_pkg::CNT_W-1:0] entry_count;
  logic [lwsel_pkg::CNT_W-1:0] ptr;
  logic                        rd_valid;
  logic [lwsel_pkg::IDX_W-1:0] rd_idx;

  // The item in work.
  logic [1:0]                  op_q;
  logic [lwsel_pkg::KEY_W-1:0] key_q;
  logic                        en_q;
  logic [15:0]                 load_q;
  logic [15:0]                 limit_q;

  // Scan results.
  logic                        dup;
  logic                        found;
  logic [lwsel_pkg::IDX_W-1:0] best_idx;
  logic [lwsel_pkg::KEY_W-1:0] best_key;
  logic [15:0]                 best_load;

  logic in_take;
  logic out_free;
  logic finish_go;
  logic scan_issue;
  logic eligible;
  logic table_full;

  assign in_stall   = (state != S_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign finish_go  = (state == S_FINISH) && out_free;
  assign scan_issue = (state == S_SCAN) && (ptr < entry_count);
  assign table_full = (entry_count >= lwsel_pkg::CNT_W'(lwsel_pkg::MAX_WORKERS));
  assign rd_addr    = ptr[lwsel_pkg::IDX_W-1:0];
  assign wr_addr    = entry_count[lwsel_pkg::IDX_W-1:0];

  // An entry can take work when it is enabled and strictly below its capacity.
  assign eligible = rd_data.en && (rd_data.load < rd_data.limit);

  // The record is appended only once the add has cleared both the duplicate and full checks
  // and its result is being handed to the output register.
  assign mem_we       = finish_go && (op_q == lwsel_pkg::OP_ADD) && !dup && !table_full;
  assign wr_data.key   = key_q;
  assign wr_data.en    = en_q;
  assign wr_data.load  = load_q;
  assign wr_data.limit = limit_q;

  // Reads of the written entry are never evaluated: the write happens in the finishing
  // cycle and the next scan cannot issue its first read before the following cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      ptr         <= '0;
      rd_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !finish_go) begin
        out_valid <= 1'b0;
      end

      // Evaluate the record read in the previous cycle, whatever the state.
      if (rd_valid) begin
        if (op_q == lwsel_pkg::OP_ADD && rd_data.key == key_q) begin
          dup <= 1'b1;
        end
        if (op_q == lwsel_pkg::OP_SELECT && eligible &&
            (!found || rd_data.load < best_load)) begin
          found     <= 1'b1;
          best_idx  <= rd_idx;
          best_key  <= rd_data.key;
          best_load <= rd_data.load;
        end
      end

      case (state)
        S_IDLE: begin
          rd_valid <= 1'b0;
          if (in_take) begin
            op_q    <= operation;
            key_q   <= worker_key[lwsel_pkg::KEY_W-1:0];
            en_q    <= worker_enabled;
            load_q  <= worker_load;
            limit_q <= worker_limit;
            ptr     <= '0;
            dup     <= 1'b0;
            found   <= 1'b0;
            if (operation == lwsel_pkg::OP_ADD || operation == lwsel_pkg::OP_SELECT) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            rd_valid <= 1'b1;
            rd_idx   <= rd_addr;
            ptr      <= ptr + 1'b1;
          end else begin
            // The last record read is evaluated in this cycle.
            rd_valid <= 1'b0;
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          rd_valid <= 1'b0;
          if (finish_go) begin
            out_valid <= 1'b1;
            case (op_q)
              lwsel_pkg::OP_ADD: begin
                chosen_index <= '0;
                chosen_key   <= '0;
                chosen_load  <= '0;
                if (dup) begin
                  status <= lwsel_pkg::ST_DUPLICATE;
                end else if (table_full) begin
                  status <= lwsel_pkg::ST_FULL;
                end else begin
                  status      <= lwsel_pkg::ST_OK;
                  entry_count <= entry_count + 1'b1;
                end
              end
              lwsel_pkg::OP_SELECT: begin
                if (found) begin
                  status       <= lwsel_pkg::ST_OK;
                  chosen_index <= 4'(best_idx);
                  chosen_key   <= 32'(best_key);
                  chosen_load  <= best_load;
                end else begin
                  status       <= lwsel_pkg::ST_NONE;
                  chosen_index <= '0;
                  chosen_key   <= '0;
                  chosen_load  <= '0;
                end
              end
              lwsel_pkg::OP_CLEAR: begin
                status       <= lwsel_pkg::ST_OK;
                chosen_index <= '0;
                chosen_key   <= '0;
                chosen_load  <= '0;
                entry_count  <= '0;
              end
              default: begin
                status       <= lwsel_pkg::ST_OK;
                chosen_index <= '0;
                chosen_key   <= '0;
                chosen_load  <= '0;
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never runs past the table size.
  assert property (@(posedge clk) disable iff (rst)
    entry_count <= lwsel_pkg::CNT_W'(lwsel_pkg::MAX_WORKERS))
    else $error("entry count beyond table size");

  // Read data is only being evaluated while a scan is under way.
  assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> state == S_SCAN)
    else $error("read data outside a scan");

  // A table write only ever lands on the first free entry and grows the table by one.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |=> entry_count == $past(entry_count) + 1'b1)
    else $error("append did not advance the fill count");

  // A finished clear leaves an empty table.
  assert property (@(posedge clk) disable iff (rst)
    (finish_go && op_q == lwsel_pkg::OP_CLEAR) |=> entry_count == '0)
    else $error("clear did not empty the table");

  // A result with a status other than OK carries no chosen worker.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != lwsel_pkg::ST_OK) |->
      (chosen_index == '0 && chosen_key == '0 && chosen_load == '0))
    else $error("chosen fields set on a failed result");

endmodule
